// File: hw/rtl/kcct_pkg.sv
// Package with shared constants and types for the k-mer copy call table.
package kcct_pkg;

   localparam int unsigned Entries = 1024;
   localparam int unsigned SlotW = 10;
   localparam int unsigned KeyW = 62;
   localparam int unsigned CountW = 32;
   localparam int unsigned CallW = 64;
   localparam int unsigned SampW = 6;

   typedef logic [SlotW-1:0] slot_type;
   typedef logic [KeyW-1:0] key_type;
   typedef logic [CountW-1:0] count_type;
   typedef logic [CallW-1:0] calls_type;
   typedef logic [2:0] status_type;
   typedef logic [2:0] csr_index_type;

   localparam status_type ST_IGNORED = 3'd0;
   localparam status_type ST_STORED = 3'd1;
   localparam status_type ST_ERASED = 3'd2;
   localparam status_type ST_UPDATED = 3'd3;
   localparam status_type ST_ABSENT = 3'd4;
   localparam status_type ST_FULL = 3'd5;
   localparam status_type ST_READ = 3'd6;

   localparam csr_index_type CSR_SAMPLE = 3'd0;
   localparam csr_index_type CSR_ZERO_MAX = 3'd1;
   localparam csr_index_type CSR_ONE_MIN = 3'd2;
   localparam csr_index_type CSR_ONE_MAX = 3'd3;
   localparam csr_index_type CSR_PRESENCE = 3'd4;

   localparam logic [0:0] OP_RECORD = 1'b0;
   localparam logic [0:0] OP_READ = 1'b1;

endpackage

// File: hw/rtl/kmer_copy_call_table.sv
// Top level of the k-mer copy call table: search sequencer and slot memories.
// A read op loads its result from both memories read at the requested slot; a record op
// scans every slot through the single read port of the key memory, one slot a cycle, then
// reads and rewrites the call word. One item at a time; the next can be accepted the cycle
// after the result is loaded, and a result stall holds the sequencer. After a synchronous
// reset a clearing pass zeroes the live bits of the key memory before items are taken.
module kmer_copy_call_table (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_opcode,
   input  kcct_pkg::key_type        req_kmer_code,
   input  kcct_pkg::count_type      req_kmer_count,
   input  logic                     req_sampled,
   input  kcct_pkg::slot_type       req_read_slot,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output kcct_pkg::status_type     rsp_status,
   output kcct_pkg::slot_type       rsp_slot,
   output logic                     rsp_entry_valid,
   output kcct_pkg::key_type        rsp_entry_kmer,
   output kcct_pkg::calls_type      rsp_entry_calls,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  kcct_pkg::csr_index_type  csr_index,
   input  logic [31:0]              csr_wdata
);
   import kcct_pkg::*;

   // Sequencer states. CLEAR walks the key memory after reset and clears the
   // live bits. SCAN walks the key memory; the read data of slot n arrives
   // while address n+1 is presented. CALLRD fetches the call word of the
   // matched or first free slot, MODIFY writes it back and forms the result.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_CALLRD = 6'b000100,
      S_MODIFY = 6'b001000,
      S_READ   = 6'b010000,
      S_CLEAR  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [SampW-1:0] sample_ff;
   count_type zero_max_ff, one_min_ff, one_max_ff, presence_ff;

   // Latched item.
   key_type key_ff;
   count_type count_ff;
   logic sampled_ff;
   slot_type rslot_ff;

   // Memories: each key word carries the live bit of its slot in the top bit.
   logic [KeyW:0] key_mem [Entries];
   calls_type call_mem [Entries];
   logic [KeyW:0] key_rd_ff;
   calls_type call_rd_ff;

   // Scan bookkeeping.
   slot_type addr_ff, addr_in;        // scan or clear address of the key memory
   slot_type cmp_ff;                  // slot whose key data is on key_rd_ff
   logic cmp_vld_ff;
   logic hit_ff, hit_in;
   slot_type hit_slot_ff, hit_slot_in;
   logic free_ff, free_in;
   slot_type free_slot_ff, free_slot_in;
   logic done_ff, done_in;            // last address has been issued

   // Result register.
   logic rsp_valid_ff;
   status_type rsp_status_ff;
   slot_type rsp_slot_ff;
   logic rsp_ev_ff;
   key_type rsp_key_ff;
   calls_type rsp_calls_ff;

   logic accept, out_free, load_rsp;
   status_type res_status;
   slot_type res_slot;
   logic res_ev;
   key_type res_key;
   calls_type res_calls;

   logic key_we, call_we;
   slot_type wr_slot;
   logic [KeyW:0] key_wdata;
   calls_type call_wdata;
   slot_type call_raddr;
   slot_type key_raddr;

   // Role decisions on the latched count.
   logic fp_take, sp_take, sp_outside, pg_take;
   calls_type pg_add;
   logic [6:0] pg_shift;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign csr_ready = (state_ff == S_IDLE);

   assign fp_take = sampled_ff && (count_ff >= one_min_ff) && (count_ff <= one_max_ff);
   assign sp_take = count_ff > zero_max_ff;
   assign sp_outside = (count_ff < one_min_ff) || (count_ff > one_max_ff);
   assign pg_take = count_ff >= presence_ff;
   assign pg_shift = {sample_ff - 6'd1, 1'b0};

   always_comb begin
      pg_add = '0;
      if (sample_ff != '0 && pg_shift < 7'd64) begin
         pg_add = (count_ff > presence_ff) ? calls_type'(1) : calls_type'(3);
         pg_add = pg_add << pg_shift[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= SampW'(1);
         zero_max_ff <= '0;
         one_min_ff <= '0;
         one_max_ff <= '1;
         presence_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SAMPLE:   sample_ff <= csr_wdata[SampW-1:0];
            CSR_ZERO_MAX: zero_max_ff <= csr_wdata;
            CSR_ONE_MIN:  one_min_ff <= csr_wdata;
            CSR_ONE_MAX:  one_max_ff <= csr_wdata;
            CSR_PRESENCE: presence_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_kmer_code;
         count_ff <= req_kmer_count;
         sampled_ff <= req_sampled;
         rslot_ff <= req_read_slot;
      end
   end

   // Key memory: one read port, one write port. A read op presents the
   // requested slot at acceptance and holds it while the result waits.
   assign key_raddr = (state_ff == S_IDLE) ? req_read_slot :
                      (state_ff == S_READ) ? rslot_ff : addr_ff;
   always_ff @(posedge clock) begin
      if (key_we) key_mem[wr_slot] <= key_wdata;
      key_rd_ff <= key_mem[key_raddr];
   end

   // Call memory: read the matched or requested slot, write the modified word.
   assign call_raddr = (state_ff == S_IDLE) ? req_read_slot :
                       (state_ff == S_READ) ? rslot_ff : hit_slot_ff;
   always_ff @(posedge clock) begin
      if (call_we) call_mem[wr_slot] <= call_wdata;
      call_rd_ff <= call_mem[call_raddr];
   end

   // Scan pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         addr_ff <= '0;
      end else begin
         cmp_vld_ff <= (state_ff == S_SCAN) && !done_ff;
         addr_ff <= addr_in;
      end
      cmp_ff <= addr_ff;
      hit_ff <= hit_in;
      hit_slot_ff <= hit_slot_in;
      free_ff <= free_in;
      free_slot_ff <= free_slot_in;
      done_ff <= done_in;
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff;
      hit_in = hit_ff;
      hit_slot_in = hit_slot_ff;
      free_in = free_ff;
      free_slot_in = free_slot_ff;
      done_in = done_ff;
      load_rsp = 1'b0;
      res_status = ST_IGNORED;
      res_slot = '0;
      res_ev = 1'b0;
      res_key = '0;
      res_calls = '0;
      key_we = 1'b0;
      call_we = 1'b0;
      wr_slot = hit_slot_ff;
      key_wdata = {1'b1, key_ff};
      call_wdata = call_rd_ff;

      case (state_ff)
         S_CLEAR: begin
            key_we = 1'b1;
            wr_slot = addr_ff;
            key_wdata = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == slot_type'(Entries - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            addr_in = '0;
            hit_in = 1'b0;
            free_in = 1'b0;
            done_in = 1'b0;
            if (accept) begin
               if (req_opcode == OP_READ) state_in = S_READ;
               else state_in = S_SCAN;
            end
         end
         S_READ: begin
            if (out_free) begin
               load_rsp = 1'b1;
               res_status = ST_READ;
               res_slot = rslot_ff;
               // Both memories were read at the requested slot; the top key bit is live.
               if (key_rd_ff[KeyW]) begin
                  res_ev = 1'b1;
                  res_key = key_rd_ff[KeyW-1:0];
                  res_calls = call_rd_ff;
               end
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!done_ff) begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == slot_type'(Entries - 1)) done_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               if (!hit_ff && key_rd_ff[KeyW] && key_rd_ff[KeyW-1:0] == key_ff) begin
                  hit_in = 1'b1;
                  hit_slot_in = cmp_ff;
               end
               if (!free_ff && !key_rd_ff[KeyW]) begin
                  free_in = 1'b1;
                  free_slot_in = cmp_ff;
               end
            end
            if (done_ff && !cmp_vld_ff) begin
               if (!hit_in && free_in) hit_slot_in = free_slot_in;
               state_in = S_CALLRD;
            end
         end
         S_CALLRD: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
               wr_slot = hit_slot_ff;
               if (sample_ff == SampW'(1)) begin
                  if (fp_take) begin
                     if (hit_ff || free_ff) begin
                        key_we = 1'b1;
                        call_we = 1'b1;
                        call_wdata = calls_type'(1);
                        res_status = ST_STORED;
                        res_slot = hit_slot_ff;
                     end else begin
                        res_status = ST_FULL;
                     end
                  end
               end else if (sample_ff == SampW'(2)) begin
                  if (sp_take) begin
                     if (!hit_ff) begin
                        res_status = ST_ABSENT;
                     end else if (sp_outside) begin
                        key_we = 1'b1;
                        key_wdata = {1'b0, key_ff};
                        res_status = ST_ERASED;
                        res_slot = hit_slot_ff;
                     end else begin
                        call_we = 1'b1;
                        call_wdata = call_rd_ff + calls_type'(4);
                        res_status = ST_UPDATED;
                        res_slot = hit_slot_ff;
                     end
                  end
               end else begin
                  if (pg_take) begin
                     if (!hit_ff) begin
                        res_status = ST_ABSENT;
                     end else begin
                        call_we = 1'b1;
                        call_wdata = call_rd_ff + pg_add;
                        res_status = ST_UPDATED;
                        res_slot = hit_slot_ff;
                     end
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff <= res_slot;
         rsp_ev_ff <= res_ev;
         rsp_key_ff <= res_key;
         rsp_calls_ff <= res_calls;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_entry_valid = rsp_ev_ff;
   assign rsp_entry_kmer = rsp_key_ff;
   assign rsp_entry_calls = rsp_calls_ff;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the k-mer copy call table with its own table predictor.
`timescale 1ns / 1ps

import kcct_pkg::*;

// Holds a predicted copy of the table and the results that are still due.
class call_table_board;
   typedef struct {
      status_type status;
      slot_type   slot;
      logic       entry_valid;
      key_type    entry_kmer;
      calls_type  entry_calls;
   } outcome_type;

   bit        live[Entries];
   key_type   keys[Entries];
   calls_type calls[Entries];
   logic [5:0] sample_idx = 6'd1;
   count_type zero_max = '0;
   count_type one_min = '0;
   count_type one_max = '1;
   count_type presence = '0;
   outcome_type due[$];
   int        errors = 0;

   function void configure(csr_index_type idx, logic [31:0] value);
      case (idx)
         CSR_SAMPLE:   sample_idx = value[5:0];
         CSR_ZERO_MAX: zero_max = value;
         CSR_ONE_MIN:  one_min = value;
         CSR_ONE_MAX:  one_max = value;
         CSR_PRESENCE: presence = value;
         default: ;
      endcase
   endfunction

   function int lookup(key_type k);
      for (int i = 0; i < Entries; i++)
         if (live[i] && keys[i] == k) return i;
      return -1;
   endfunction

   function int first_free();
      for (int i = 0; i < Entries; i++)
         if (!live[i]) return i;
      return -1;
   endfunction

   // Works out the result of one accepted item and updates the predicted table.
   function void note_request(logic op, key_type k, count_type cnt, logic smp, slot_type rs);
      outcome_type o;
      int        s;
      calls_type add;
      o = '{ST_IGNORED, '0, 1'b0, '0, '0};
      if (op == OP_READ) begin
         o.status = ST_READ;
         o.slot = rs;
         if (live[rs]) begin
            o.entry_valid = 1'b1;
            o.entry_kmer = keys[rs];
            o.entry_calls = calls[rs];
         end
      end else if (sample_idx == 6'd1) begin
         if (smp && cnt >= one_min && cnt <= one_max) begin
            s = lookup(k);
            if (s < 0) s = first_free();
            if (s < 0) begin
               o.status = ST_FULL;
            end else begin
               live[s] = 1'b1;
               keys[s] = k;
               calls[s] = 64'd1;
               o.status = ST_STORED;
               o.slot = slot_type'(s);
            end
         end
      end else if (sample_idx == 6'd2) begin
         if (cnt > zero_max) begin
            s = lookup(k);
            if (s < 0) begin
               o.status = ST_ABSENT;
            end else if (cnt < one_min || cnt > one_max) begin
               live[s] = 1'b0;
               o.status = ST_ERASED;
               o.slot = slot_type'(s);
            end else begin
               calls[s] = calls[s] + 64'd4;
               o.status = ST_UPDATED;
               o.slot = slot_type'(s);
            end
         end
      end else begin
         if (cnt >= presence) begin
            s = lookup(k);
            if (s < 0) begin
               o.status = ST_ABSENT;
            end else begin
               add = '0;
               if (sample_idx >= 6'd1 && sample_idx <= 6'd32)
                  add = ((cnt > presence) ? 64'd1 : 64'd3) << (2 * (sample_idx - 1));
               calls[s] = calls[s] + add;
               o.status = ST_UPDATED;
               o.slot = slot_type'(s);
            end
         end
      end
      due.insert(due.size(), o);
   endfunction

   function void check_result(status_type st, slot_type sl, logic ev, key_type ek,
                              calls_type ec);
      outcome_type o;
      if (due.size() == 0) begin
         $error("Result transfer with no result due: status %0d slot %0d", st, sl);
         errors++;
         return;
      end
      o = due.pop_front();
      if (st !== o.status) begin
         $error("status: expected %0d, actual %0d", o.status, st);
         errors++;
      end
      if (sl !== o.slot) begin
         $error("slot: expected %0d, actual %0d", o.slot, sl);
         errors++;
      end
      if (ev !== o.entry_valid) begin
         $error("entry_valid: expected %0d, actual %0d", o.entry_valid, ev);
         errors++;
      end
      if (ek !== o.entry_kmer) begin
         $error("entry_kmer: expected %h, actual %h", o.entry_kmer, ek);
         errors++;
      end
      if (ec !== o.entry_calls) begin
         $error("entry_calls: expected %h, actual %h", o.entry_calls, ec);
         errors++;
      end
   endfunction

   function int pending();
      return due.size();
   endfunction
endclass

module testbench;
   // Run limit in clock cycles; a record op scans every slot of the table.
   localparam int CycleLimit = 8000000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_opcode = OP_RECORD;
   key_type       req_kmer_code = '0;
   count_type     req_kmer_count = '0;
   logic          req_sampled = 1'b0;
   slot_type      req_read_slot = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   status_type    rsp_status;
   slot_type      rsp_slot;
   logic          rsp_entry_valid;
   key_type       rsp_entry_kmer;
   calls_type     rsp_entry_calls;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_SAMPLE;
   logic [31:0]   csr_wdata = '0;

   call_table_board board;
   key_type   key_pool[24];
   bit        steady = 1'b0;   // When set, neither side inserts gaps or stalls.
   longint    cycles = 0;

   kmer_copy_call_table dut (.*);

   always #5 clock = ~clock;

   // Run limit: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: check each transfer, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_status, rsp_slot, rsp_entry_valid, rsp_entry_kmer,
                            rsp_entry_calls);
      if (reset || steady)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < 10);
   end

   // Offers one item and returns at the edge of its transfer, with valid left high
   // so back-to-back items need no extra cycle.
   task automatic send_item(logic op, key_type k, count_type cnt, logic smp, slot_type rs);
      int gap;
      if (!steady && $urandom_range(99) < 10) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_kmer_code <= k;
      req_kmer_count <= cnt;
      req_sampled <= smp;
      req_read_slot <= rs;
      do @(posedge clock); while (req_stall);
      board.note_request(op, k, cnt, smp, rs);
   endtask

   task automatic record(key_type k, count_type cnt, logic smp = 1'b1);
      send_item(OP_RECORD, k, cnt, smp, slot_type'($urandom));
   endtask

   task automatic read_slot(slot_type rs);
      send_item(OP_READ, key_type'({$urandom, $urandom}), $urandom,
                1'($urandom_range(1)), rs);
   endtask

   // Waits until every result has come back, so the block is idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle.
   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.configure(idx, value);
   endtask

   task automatic set_bands(logic [31:0] zmax, logic [31:0] omin, logic [31:0] omax,
                            logic [31:0] pres);
      write_reg(CSR_ZERO_MAX, zmax);
      write_reg(CSR_ONE_MIN, omin);
      write_reg(CSR_ONE_MAX, omax);
      write_reg(CSR_PRESENCE, pres);
   endtask

   // Counts cluster on the edges of the current bands, where decisions flip.
   function automatic count_type pick_count();
      case ($urandom_range(11))
         0: return board.zero_max;
         1: return board.zero_max + 1;
         2: return board.one_min - 1;
         3: return board.one_min;
         4: return board.one_max;
         5: return board.one_max + 1;
         6: return board.presence - 1;
         7: return board.presence;
         8: return board.presence + 1;
         9: return '0;
         10: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly pooled keys so that matches, updates and erasures occur; some fresh keys.
   task automatic random_mix(int items, int read_pct);
      key_type k;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < read_pct) begin
            read_slot(($urandom_range(9) == 0) ? slot_type'($urandom)
                                               : slot_type'($urandom_range(40)));
         end else begin
            k = ($urandom_range(4) == 0) ? key_type'({$urandom, $urandom})
                                         : key_pool[$urandom_range(23)];
            record(k, pick_count(), $urandom_range(99) < 85);
         end
      end
   endtask

   initial begin
      board = new();
      foreach (key_pool[i])
         key_pool[i] = key_type'({$urandom, $urandom});
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First parent, directed: band edges, the subsample bit, overwrite, key extremes.
      write_reg(CSR_SAMPLE, 32'd1);
      set_bands(32'd5, 32'd10, 32'd100, 32'd50);
      record(key_pool[0], 32'd50, 1'b0);
      record(key_pool[0], 32'd9);
      record(key_pool[0], 32'd101);
      record(key_pool[0], 32'd10);
      record(key_pool[1], 32'd100);
      record(key_pool[2], 32'd55);
      record(key_pool[1], 32'd20);
      read_slot(10'd0);
      read_slot(10'd1);
      read_slot(10'd2);
      read_slot(10'd1023);
      steady = 1'b1;
      random_mix(40, 30);
      steady = 1'b0;
      random_mix(110, 30);

      // Second parent: ignore, erase below and above the band, confirm, absent key.
      write_reg(CSR_SAMPLE, 32'd2);
      record(key_pool[0], 32'd5);
      record(key_pool[0], 32'd6);
      record(key_pool[1], 32'd60);
      record(key_pool[2], 32'd101);
      record(key_pool[3] ^ key_type'(1), 32'd60);
      read_slot(10'd1);
      random_mix(100, 25);
      set_bands(32'd0, 32'd0, 32'd0, 32'd0);
      random_mix(20, 20);
      set_bands(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
      random_mix(10, 20);

      // Progeny passes, including indexes outside the call field and wrapping sums.
      set_bands(32'd5, 32'd10, 32'd100, 32'd50);
      write_reg(CSR_SAMPLE, 32'd3);
      record(key_pool[4], 32'd49);
      record(key_pool[4], 32'd50);
      record(key_pool[4], 32'd51);
      random_mix(40, 25);
      write_reg(CSR_SAMPLE, 32'd32);
      random_mix(40, 25);
      write_reg(CSR_PRESENCE, 32'hFFFF_FFFF);
      random_mix(25, 25);
      write_reg(CSR_PRESENCE, 32'd0);
      write_reg(CSR_SAMPLE, 32'd0);
      random_mix(20, 25);
      write_reg(CSR_SAMPLE, 32'd33);
      random_mix(15, 25);
      write_reg(CSR_SAMPLE, 32'hFFFF_FFFF);
      random_mix(15, 25);
      write_reg(CSR_SAMPLE, 32'd17);
      write_reg(CSR_PRESENCE, 32'd1000);
      random_mix(30, 25);

      // First parent again with the widest band: a burst of fresh keys into free slots.
      write_reg(CSR_SAMPLE, 32'd1);
      set_bands(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0);
      for (int i = 0; i < 60; i++)
         record(key_type'({$urandom, $urandom}), $urandom);
      for (int i = 0; i < 12; i++)
         read_slot(slot_type'($urandom));
      random_mix(20, 30);

      settle();
      if (board.errors == 0 && board.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
